>>> hw/rtl/phcc_pkg.sv
package phcc_pkg;

	// object table size and derived widths
	localparam int NUM_OBJECTS = 256;
	localparam int ID_W        = 8;
	localparam int ADDR_W      = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
	localparam int STEP_W      = $clog2(NUM_OBJECTS + 1);

	// command codes carried on tuser
	typedef enum logic [1:0] {
		CMD_SET_PARENT   = 2'd0,
		CMD_CLEAR_PARENT = 2'd1,
		CMD_SET_VISIBLE  = 2'd2,
		CMD_QUERY        = 2'd3
	} cmd_t;

	// one entry of the link store
	typedef struct packed {
		logic            visible;
		logic [ID_W-1:0] parent;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hw/rtl/phcc_ram.sv
module phcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> hw/rtl/phcc_store.sv
module phcc_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [phcc_pkg::ADDR_W-1:0]   rd_addr,
	output phcc_pkg::entry_t              rd_entry,
	input  logic                          wr_en,
	input  logic [phcc_pkg::ADDR_W-1:0]   wr_addr,
	input  phcc_pkg::entry_t              wr_entry
);

	import phcc_pkg::*;

	logic [NUM_OBJECTS-1:0] valid_q;
	logic                   rd_valid_q;
	logic [ADDR_W-1:0]      rd_addr_q;
	logic [ENTRY_W-1:0]     ram_rdata;

	phcc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_OBJECTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// per-entry written flags, and the written flag of the read in flight; its address is registered below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
	end

	// an entry never written reads as a visible root
	always_comb begin
		if (rd_valid_q) begin
			rd_entry = entry_t'(ram_rdata);
		end else begin
			rd_entry.visible = 1'b1;
			rd_entry.parent  = ID_W'(rd_addr_q);
		end
	end

endmodule

>>> hw/rtl/parent_hierarchy_cycle_check.sv
// channel   dir  tdata (lsb up)                                         tuser
// s_*       in   object_id[7:0] parent_id[15:8] visible_value[16]      command[1:0]
//                chain_walk[17], zero fill to 24 bits
// m_*       out  status[0] is_visible[1], zero fill to 8 bits          -
//
// one item at a time; a transfer reads the object in S_OBJ and then goes to S_RESULT for
// clear parent, set visible and a plain query; out-of-range ids go straight to S_RESULT
// set parent and a chained query that goes past the object walk the ancestors in S_WALK, up to
// a step count of NUM_OBJECTS: each step is one read of the single-read-port link store
// s_tready is high only when the sequencer is idle; a stalled result waits in the output
// register while the next item is taken
// asynchronous reset marks all entries unwritten, so every object is a visible root
module parent_hierarchy_cycle_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // object_id, parent_id, visible_value, chain_walk
	input  logic [1:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status, is_visible
);

	import phcc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_OBJ,
		S_WALK,
		S_RESULT
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] obj_q;
	logic [ADDR_W-1:0] par_q;
	logic              vis_val_q;
	logic              chain_q;
	logic [ADDR_W-1:0] head_q;
	logic [STEP_W-1:0] steps_q;
	logic              vis_obj_q;
	logic              status_q;
	logic              answer_q;
	logic              m_tvalid_q;
	logic              res_status_q;
	logic              res_visible_q;

	logic [ID_W-1:0]   in_obj;
	logic [ID_W-1:0]   in_par;
	logic              in_obj_ok;
	logic              in_par_ok;
	logic              accept;
	logic              out_load;

	entry_t            ent;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_entry;
	logic              step_end;
	logic              up_is_head;
	logic              up_is_obj;

	assign in_obj    = s_tdata[7:0];
	assign in_par    = s_tdata[15:8];
	assign in_obj_ok = {1'b0, in_obj} < (ID_W + 1)'(NUM_OBJECTS);
	assign in_par_ok = {1'b0, in_par} < (ID_W + 1)'(NUM_OBJECTS);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, res_visible_q, res_status_q};

	// output register takes the result once it is free or being drained
	assign out_load = (state_q == S_RESULT) && (!m_tvalid_q || m_tready);

	phcc_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_entry (ent),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	// walk compares on the entry just read
	assign step_end   = (steps_q == STEP_W'(NUM_OBJECTS));
	assign up_is_head = (ent.parent == ID_W'(head_q));
	assign up_is_obj  = (ent.parent == ID_W'(obj_q));

	// next read: the object on a transfer, then the new parent or the next ancestor
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = in_obj[ADDR_W-1:0];
			S_OBJ:   rd_addr = (cmd_q == CMD_SET_PARENT) ? par_q : ent.parent[ADDR_W-1:0];
			S_WALK:  rd_addr = ent.parent[ADDR_W-1:0];
			default: rd_addr = head_q;
		endcase
	end

	// store updates, always on the object itself
	always_comb begin
		wr_en            = 1'b0;
		wr_addr          = obj_q;
		wr_entry.visible = ent.visible;
		wr_entry.parent  = ent.parent;
		if (state_q == S_OBJ) begin
			if (cmd_q == CMD_CLEAR_PARENT) begin
				wr_en           = 1'b1;
				wr_entry.parent = ID_W'(obj_q);
			end else if (cmd_q == CMD_SET_VISIBLE) begin
				wr_en            = 1'b1;
				wr_entry.visible = vis_val_q;
			end
		end else if (state_q == S_WALK && cmd_q == CMD_SET_PARENT) begin
			wr_en            = !step_end && up_is_head;
			wr_entry.visible = vis_obj_q;
			wr_entry.parent  = ID_W'(par_q);
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= CMD_SET_PARENT;
			obj_q         <= '0;
			par_q         <= '0;
			vis_val_q     <= 1'b0;
			chain_q       <= 1'b0;
			head_q        <= '0;
			steps_q       <= '0;
			vis_obj_q     <= 1'b0;
			status_q      <= 1'b0;
			answer_q      <= 1'b0;
			m_tvalid_q    <= 1'b0;
			res_status_q  <= 1'b0;
			res_visible_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= cmd_t'(s_tuser);
						obj_q     <= in_obj[ADDR_W-1:0];
						par_q     <= in_par[ADDR_W-1:0];
						vis_val_q <= s_tdata[16];
						chain_q   <= s_tdata[17];
						head_q    <= in_obj[ADDR_W-1:0];
						steps_q   <= '0;
						status_q  <= 1'b0;
						answer_q  <= 1'b0;
						if (!in_obj_ok ||
						    (cmd_t'(s_tuser) == CMD_SET_PARENT && !in_par_ok)) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_OBJ;
						end
					end
				end
				S_OBJ: begin
					unique case (cmd_q)
						CMD_SET_PARENT: begin
							vis_obj_q <= ent.visible;
							head_q    <= par_q;
							steps_q   <= '0;
							state_q   <= S_WALK;
						end
						CMD_CLEAR_PARENT, CMD_SET_VISIBLE: begin
							state_q <= S_RESULT;
						end
						CMD_QUERY: begin
							if (!chain_q || !ent.visible) begin
								answer_q <= ent.visible;
								state_q  <= S_RESULT;
							end else if (up_is_head) begin
								answer_q <= 1'b1;
								state_q  <= S_RESULT;
							end else begin
								head_q  <= ent.parent[ADDR_W-1:0];
								steps_q <= STEP_W'(1);
								state_q <= S_WALK;
							end
						end
					endcase
				end
				S_WALK: begin
					if (cmd_q == CMD_SET_PARENT) begin
						// refuse when the object turns up above the new parent or the step bound is reached
						if (step_end || (!up_is_head && up_is_obj)) begin
							status_q <= 1'b1;
							state_q  <= S_RESULT;
						end else if (up_is_head) begin
							state_q <= S_RESULT;
						end else begin
							head_q  <= ent.parent[ADDR_W-1:0];
							steps_q <= steps_q + STEP_W'(1);
						end
					end else begin
						// chained visibility: stop at a hidden ancestor, the root or the step bound
						if (!ent.visible) begin
							answer_q <= 1'b0;
							state_q  <= S_RESULT;
						end else if (step_end || up_is_head) begin
							answer_q <= 1'b1;
							state_q  <= S_RESULT;
						end else begin
							head_q  <= ent.parent[ADDR_W-1:0];
							steps_q <= steps_q + STEP_W'(1);
						end
					end
				end
				S_RESULT: begin
					if (out_load) begin
						res_status_q  <= status_q;
						res_visible_q <= answer_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a refused link never comes with a visibility answer
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("status and is_visible both set");

	// the ancestor walk stays within its bound
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> steps_q <= STEP_W'(NUM_OBJECTS))
		else $error("walk step count beyond table size");

	// a transfer always starts work
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != S_IDLE)
		else $error("sequencer idle after an input transfer");

	// only a set parent can end with a refusal
	a_status_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESULT && status_q |-> cmd_q == CMD_SET_PARENT)
		else $error("refusal on a command other than set parent");

endmodule

>>> bench/tb_parent_hierarchy_cycle_check.sv
`timescale 1ns / 100ps

module tb_parent_hierarchy_cycle_check;

	import phcc_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 11;
	localparam int ITEM_TARGET  = 1750;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int MAX_IDLE     = 5;

	// one command as offered on the input stream
	typedef struct packed {
		cmd_t            cmd;
		logic [ID_W-1:0] obj;
		logic [ID_W-1:0] par;
		logic            vis;
		logic            chain;
	} hier_cmd_t;

	// one answer as returned on the output stream
	typedef struct packed {
		logic refused;
		logic shown;
	} hier_reply_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = CMD_SET_PARENT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	hier_cmd_t   cmd_queue[$];
	hier_reply_t pending_replies[$];
	hier_cmd_t   offered_cmd;

	// shadow copy of the link store and the visible bits
	logic [ID_W-1:0] link_tbl [NUM_OBJECTS];
	logic            shown_tbl[NUM_OBJECTS];

	int unsigned gap_left    = 0;
	int unsigned stall_left  = 0;
	int unsigned hold_left   = 0;
	int unsigned next_hold   = 100;
	int unsigned replies_in  = 0;
	int unsigned cycle_count = 0;
	int unsigned items_made  = 0;
	int          errors      = 0;
	logic        tx_quiet    = 1'b0;
	logic        rx_quiet    = 1'b0;

	parent_hierarchy_cycle_check i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// does the walk up from start run into obj
	function automatic logic walk_meets(input logic [ID_W-1:0] start, input logic [ID_W-1:0] obj);
		logic [ID_W-1:0] head;
		logic [ID_W-1:0] up;
		head = start;
		for (int n = 0; n < NUM_OBJECTS; n++) begin
			up = link_tbl[head];
			if (up == head)
				return 1'b0;
			head = up;
			if (head == obj)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// and of the visible bits from obj up to its root
	function automatic logic chain_shown(input logic [ID_W-1:0] obj);
		logic [ID_W-1:0] head;
		logic [ID_W-1:0] up;
		head = obj;
		if (!shown_tbl[head])
			return 1'b0;
		for (int n = 0; n < NUM_OBJECTS; n++) begin
			up = link_tbl[head];
			if (up == head)
				return 1'b1;
			head = up;
			if (!shown_tbl[head])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// apply one command to the shadow state and work out its answer
	function automatic hier_reply_t update_hierarchy(input hier_cmd_t c);
		hier_reply_t r;
		r = '0;
		if (c.obj < NUM_OBJECTS) begin
			case (c.cmd)
				CMD_SET_PARENT: begin
					if (c.par < NUM_OBJECTS) begin
						if (walk_meets(c.par, c.obj))
							r.refused = 1'b1;
						else
							link_tbl[c.obj] = c.par;
					end
				end
				CMD_CLEAR_PARENT: begin
					link_tbl[c.obj] = c.obj;
				end
				CMD_SET_VISIBLE: begin
					shown_tbl[c.obj] = c.vis;
				end
				default: begin
					r.shown = c.chain ? chain_shown(c.obj) : shown_tbl[c.obj];
				end
			endcase
		end
		return r;
	endfunction

	task automatic add_cmd(input cmd_t cmd, input logic [ID_W-1:0] obj, input logic [ID_W-1:0] par,
			input logic vis, input logic chain);
		hier_cmd_t c;
		c.cmd   = cmd;
		c.obj   = obj;
		c.par   = par;
		c.vis   = vis;
		c.chain = chain;
		cmd_queue.push_back(c);
		items_made++;
	endtask

	// random command, mostly inside a 16-entry window so that trees grow deep
	task automatic add_random_cmd(input logic [ID_W-1:0] base, input bit windowed);
		int unsigned pick;
		cmd_t        cmd;
		logic [ID_W-1:0] obj;
		logic [ID_W-1:0] par;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			cmd = CMD_SET_PARENT;
		else if (pick < 5)
			cmd = CMD_CLEAR_PARENT;
		else if (pick < 7)
			cmd = CMD_SET_VISIBLE;
		else
			cmd = CMD_QUERY;
		obj = windowed ? base + ID_W'($urandom_range(0, 15)) : ID_W'($urandom_range(0, 255));
		par = windowed ? base + ID_W'($urandom_range(0, 15)) : ID_W'($urandom_range(0, 255));
		add_cmd(cmd, obj, par, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// stimulus, reset and end of run
	initial begin
		int unsigned     len;
		int unsigned     stride;
		logic [ID_W-1:0] start;
		logic [ID_W-1:0] base;
		logic [ID_W-1:0] member;

		for (int i = 0; i < NUM_OBJECTS; i++) begin
			link_tbl[i]  = ID_W'(i);
			shown_tbl[i] = 1'b1;
		end

		// directed: fresh state, short chain, refusal, self link, visibility along a chain
		add_cmd(CMD_QUERY,        8'd0,   8'd0,   1'b0, 1'b0);
		add_cmd(CMD_QUERY,        8'd255, 8'd255, 1'b1, 1'b1);
		add_cmd(CMD_SET_PARENT,   8'd1,   8'd0,   1'b0, 1'b0);
		add_cmd(CMD_SET_PARENT,   8'd2,   8'd1,   1'b0, 1'b0);
		add_cmd(CMD_SET_PARENT,   8'd0,   8'd2,   1'b0, 1'b0);
		add_cmd(CMD_SET_PARENT,   8'd2,   8'd2,   1'b0, 1'b0);
		add_cmd(CMD_SET_PARENT,   8'd0,   8'd0,   1'b1, 1'b1);
		add_cmd(CMD_SET_PARENT,   8'd2,   8'd1,   1'b0, 1'b0);
		add_cmd(CMD_SET_VISIBLE,  8'd0,   8'd255, 1'b0, 1'b1);
		add_cmd(CMD_QUERY,        8'd2,   8'd0,   1'b0, 1'b0);
		add_cmd(CMD_QUERY,        8'd2,   8'd0,   1'b0, 1'b1);
		add_cmd(CMD_SET_VISIBLE,  8'd0,   8'd0,   1'b1, 1'b0);
		add_cmd(CMD_QUERY,        8'd2,   8'd0,   1'b0, 1'b1);
		add_cmd(CMD_SET_VISIBLE,  8'd1,   8'd0,   1'b0, 1'b0);
		add_cmd(CMD_CLEAR_PARENT, 8'd1,   8'd255, 1'b1, 1'b1);
		add_cmd(CMD_QUERY,        8'd2,   8'd0,   1'b0, 1'b1);
		add_cmd(CMD_SET_PARENT,   8'd255, 8'd254, 1'b1, 1'b1);
		add_cmd(CMD_SET_PARENT,   8'd254, 8'd255, 1'b0, 1'b0);
		add_cmd(CMD_SET_VISIBLE,  8'd254, 8'd0,   1'b0, 1'b0);
		add_cmd(CMD_QUERY,        8'd255, 8'd0,   1'b0, 1'b1);
		add_cmd(CMD_QUERY,        8'd255, 8'd0,   1'b0, 1'b0);
		add_cmd(CMD_CLEAR_PARENT, 8'd255, 8'd0,   1'b0, 1'b0);
		add_cmd(CMD_SET_VISIBLE,  8'd254, 8'd0,   1'b1, 1'b0);
		add_cmd(CMD_SET_VISIBLE,  8'd1,   8'd0,   1'b1, 1'b0);

		// one chain over every object, for the longest walks
		add_cmd(CMD_CLEAR_PARENT, 8'd255, 8'd0, 1'b0, 1'b0);
		for (int i = 254; i >= 0; i--)
			add_cmd(CMD_SET_PARENT, ID_W'(i), ID_W'(i + 1), 1'($urandom_range(0, 1)), 1'b0);
		add_cmd(CMD_QUERY,       8'd0,   8'd0, 1'b0, 1'b1);
		add_cmd(CMD_SET_PARENT,  8'd255, 8'd0, 1'b0, 1'b0);
		add_cmd(CMD_SET_VISIBLE, 8'd255, 8'd0, 1'b0, 1'b0);
		add_cmd(CMD_QUERY,       8'd0,   8'd0, 1'b0, 1'b1);
		add_cmd(CMD_SET_VISIBLE, 8'd255, 8'd0, 1'b1, 1'b0);

		// random: chain builds with probes, and bursts of mixed commands
		while (items_made < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0) begin
				len    = $urandom_range(3, 24);
				stride = $urandom_range(1, 3);
				start  = ID_W'($urandom_range(0, 255));
				for (int k = len - 2; k >= 0; k--)
					add_cmd(CMD_SET_PARENT, start + ID_W'(k * stride),
						start + ID_W'((k + 1) * stride), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				member = start + ID_W'($urandom_range(0, len - 1) * stride);
				add_cmd(CMD_QUERY, start, 8'd0, 1'b0, 1'b1);
				add_cmd(CMD_SET_VISIBLE, member, 8'd0, 1'b0, 1'b0);
				add_cmd(CMD_QUERY, start, 8'd0, 1'b0, 1'b1);
				add_cmd(CMD_SET_PARENT, start + ID_W'((len - 1) * stride), start, 1'b0, 1'b0);
				add_cmd(CMD_SET_VISIBLE, member, 8'd0, 1'b1, 1'b0);
			end else begin
				base = ID_W'($urandom_range(0, 255));
				repeat (20)
					add_random_cmd(base, $urandom_range(0, 9) < 7);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// checked between edges, once the driver and monitor have settled
		while (cmd_queue.size() != 0 || s_tvalid || pending_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// command driver: one transfer at a time with random gaps between them
	always @(posedge clk or negedge arst_n) begin : cmd_drive
		hier_cmd_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_replies.push_back(update_hierarchy(offered_cmd));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					nxt = cmd_queue.pop_front();
					offered_cmd <= nxt;
					s_tdata     <= {6'd0, nxt.chain, nxt.vis, nxt.par, nxt.obj};
					s_tuser     <= nxt.cmd;
					s_tvalid    <= 1'b1;
					gap_left    <= tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
					if ($urandom_range(0, 39) == 0)
						tx_quiet <= !tx_quiet;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off now and then, so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (replies_in >= next_hold) begin
			hold_left <= $urandom_range(200, 400);
			next_hold <= next_hold + 600;
		end
	end

	// reply monitor: compare each transfer with the oldest expected answer
	always @(posedge clk or negedge arst_n) begin : reply_check
		hier_reply_t want;
		int unsigned stall_n;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_n = stall_left;
			if (m_tvalid && m_tready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: reply with nothing expected, got status %0d is_visible %0d",
						$time, m_tdata[0], m_tdata[1]);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					if (m_tdata[0] !== want.refused) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.refused, m_tdata[0]);
						errors++;
					end
					if (m_tdata[1] !== want.shown) begin
						$display("%0t: is_visible mismatch, expected %0d, got %0d",
							$time, want.shown, m_tdata[1]);
						errors++;
					end
				end
				replies_in <= replies_in + 1;
				stall_n = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
				if ($urandom_range(0, 39) == 0)
					rx_quiet <= !rx_quiet;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (stall_n != 0) begin
				m_tready <= 1'b0;
				if (m_tvalid)
					stall_n--;
			end else begin
				m_tready <= 1'b1;
			end
			stall_left <= stall_n;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
